>>> design/ewqp_pkg.sv
// ----------------------------------------------------------------------------
// ewqp_pkg
// Shared sizes, codes and the controller command struct for the expander write-queue
// poller: command and action codes, register indexes, derived widths.
// ----------------------------------------------------------------------------
package ewqp_pkg;

   // Build-time sizing
   localparam int NUM_EXPANDERS = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int PIN_COUNT     = 16;

   // Field widths fixed by the interface
   localparam int CMD_W       = 2;
   localparam int EXP_W       = 3;
   localparam int PIN_W       = 5;
   localparam int WORD_W      = 16;
   localparam int EXP_MASK_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Derived widths
   localparam int SLOT_W    = (NUM_EXPANDERS > 1) ? $clog2(NUM_EXPANDERS) : 1;
   localparam int RR_W      = SLOT_W + 1;
   localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W    = CNT_W + 1;
   localparam int PIN_IDX_W = $clog2(PIN_COUNT);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_POLL       = 2'd0,
      CMD_QUEUE_PIN  = 2'd1,
      CMD_READ_DATA  = 2'd2,
      CMD_QUERY      = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

>>> design/ewqp_if.sv
// ----------------------------------------------------------------------------
// ewqp_if
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface ewqp_req_if;
   import ewqp_pkg::*;

   logic                valid;
   logic                ready;
   command_type         command;
   logic [EXP_W-1:0]    expander;
   logic [PIN_W-1:0]    pin;
   logic                pin_value;
   logic [WORD_W-1:0]   read_word;

   modport source (output valid, command, expander, pin, pin_value, read_word,
                   input ready);
   modport sink   (input valid, command, expander, pin, pin_value, read_word,
                   output ready);
endinterface

interface ewqp_rsp_if;
   import ewqp_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic [EXP_W-1:0]    target;
   logic [WORD_W-1:0]   write_word;
   logic [WORD_W-1:0]   cached_word;
   logic                pin_state;

   modport source (output valid, action, target, write_word, cached_word, pin_state,
                   input ready);
   modport sink   (input valid, action, target, write_word, cached_word, pin_state,
                   output ready);
endinterface

interface ewqp_csr_if;
   import ewqp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ewqp_ctrl.sv
// ----------------------------------------------------------------------------
// ewqp_ctrl
// Two-state sequencer: captures a request beat, then commits it into the
// response register once that register is free or draining.
// ----------------------------------------------------------------------------
module ewqp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ewqp_pkg::ctrl_cmd_type ctrl_cmd
);
   import ewqp_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      ctrl_cmd     = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.capture = 1'b1;
               state_in         = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // commit only when the response slot is empty or being taken
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl_cmd.commit = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/ewqp_datapath.sv
// ----------------------------------------------------------------------------
// ewqp_datapath
// Per-expander queues, sent-word and input-cache registers, round-robin
// pick, and the response register. The queue words sit in one memory with
// a circular head pointer and a fill count per expander.
// ----------------------------------------------------------------------------
module ewqp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ewqp_pkg::ctrl_cmd_type             ctrl_cmd,
   // register writes
   input  logic                               csr_valid,
   input  logic [ewqp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ewqp_pkg::CSR_DATA_W-1:0]    csr_data,
   // request payload
   input  ewqp_pkg::command_type              command,
   input  logic [ewqp_pkg::EXP_W-1:0]         expander,
   input  logic [ewqp_pkg::PIN_W-1:0]         pin,
   input  logic                               pin_value,
   input  logic [ewqp_pkg::WORD_W-1:0]        read_word,
   // response payload
   output ewqp_pkg::action_type               action,
   output logic [ewqp_pkg::EXP_W-1:0]         target,
   output logic [ewqp_pkg::WORD_W-1:0]        write_word,
   output logic [ewqp_pkg::WORD_W-1:0]        cached_word,
   output logic                               pin_state
);
   import ewqp_pkg::*;

   // Configuration
   logic                  block_enable_ff;
   logic [EXP_MASK_W-1:0] enable_mask_ff;

   // Per-expander state
   logic [SLOT_W-1:0]     last_served_ff;
   logic [CNT_W-1:0]      count_ff     [NUM_EXPANDERS];
   logic [QPTR_W-1:0]     head_ff      [NUM_EXPANDERS];
   logic [WORD_W-1:0]     last_sent_ff [NUM_EXPANDERS];
   logic [WORD_W-1:0]     cache_ff     [NUM_EXPANDERS];
   logic [WORD_W-1:0]     fifo_mem     [NUM_EXPANDERS][QUEUE_DEPTH];

   // Capture-side selection
   logic                  pick_found;
   logic [SLOT_W-1:0]     pick_slot;
   logic [SLOT_W-1:0]     sel_slot;
   logic                  sel_ok;
   logic [CNT_W-1:0]      sel_count;
   logic [QPTR_W-1:0]     sel_head;
   logic [QPTR_W-1:0]     rd_ptr;

   // Captured operation
   command_type           op_cmd_ff;
   logic [EXP_W-1:0]      op_expander_ff;
   logic [SLOT_W-1:0]     op_slot_ff;
   logic                  op_ok_ff;
   logic [PIN_W-1:0]      op_pin_ff;
   logic                  op_level_ff;
   logic [WORD_W-1:0]     op_read_word_ff;
   logic [CNT_W-1:0]      op_count_ff;
   logic [QPTR_W-1:0]     op_head_ff;
   logic [WORD_W-1:0]     op_last_sent_ff;
   logic [WORD_W-1:0]     op_cache_ff;
   logic [WORD_W-1:0]     mem_rd_ff;

   // Commit-side logic
   logic                  pin_ok;
   logic [PIN_IDX_W-1:0]  pin_idx;
   logic [WORD_W-1:0]     pin_mask;
   logic [WORD_W-1:0]     base_word;
   logic [WORD_W-1:0]     new_word;
   logic [QPTR_W-1:0]     tail_ptr;
   logic [QPTR_W-1:0]     head_in;
   logic [CNT_W-1:0]      count_in;
   logic                  push;
   logic                  pop;
   logic                  cache_wr;
   logic                  served_upd;

   // Response register
   action_type            action_ff;
   action_type            action_in;
   logic [EXP_W-1:0]      target_ff;
   logic [EXP_W-1:0]      target_in;
   logic [WORD_W-1:0]     write_word_ff;
   logic [WORD_W-1:0]     write_word_in;
   logic [WORD_W-1:0]     cached_word_ff;
   logic [WORD_W-1:0]     cached_word_in;
   logic                  pin_state_ff;
   logic                  pin_state_in;

   // Wrap a head-plus-offset sum back into the queue range
   function automatic logic [QPTR_W-1:0] wrap_ptr(input logic [QSUM_W-1:0] sum);
      logic [QSUM_W-1:0] adj;
      adj = sum;
      if (sum >= QSUM_W'(QUEUE_DEPTH)) begin
         adj = sum - QSUM_W'(QUEUE_DEPTH);
      end
      return adj[QPTR_W-1:0];
   endfunction

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_enable_ff <= 1'b0;
         enable_mask_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BLOCK_ENABLE: block_enable_ff <= csr_data[0];
            CSR_ENABLE_MASK:  enable_mask_ff  <= csr_data[EXP_MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Round-robin search: the slot after the last served comes first,
   // the last served slot itself comes last
   always_comb begin
      logic [RR_W-1:0] rr_cand;
      pick_found = 1'b0;
      pick_slot  = '0;
      for (int k = NUM_EXPANDERS; k >= 1; k--) begin
         rr_cand = RR_W'(last_served_ff) + RR_W'(k);
         if (rr_cand >= RR_W'(NUM_EXPANDERS)) begin
            rr_cand = rr_cand - RR_W'(NUM_EXPANDERS);
         end
         if (enable_mask_ff[rr_cand[SLOT_W-1:0]]) begin
            pick_found = 1'b1;
            pick_slot  = rr_cand[SLOT_W-1:0];
         end
      end
   end

   // Pick the slot and queue entry this beat touches
   always_comb begin
      if (command == CMD_POLL) begin
         sel_slot = pick_slot;
         sel_ok   = block_enable_ff & pick_found;
      end else begin
         sel_slot = expander[SLOT_W-1:0];
         sel_ok   = int'(expander) < NUM_EXPANDERS;
      end
      sel_count = count_ff[sel_slot];
      sel_head  = head_ff[sel_slot];
      // poll reads the head, a pin write reads the newest entry
      if (command == CMD_POLL || sel_count == '0) begin
         rd_ptr = sel_head;
      end else begin
         rd_ptr = wrap_ptr(QSUM_W'(sel_head) + QSUM_W'(sel_count) - QSUM_W'(1));
      end
   end

   // Capture the beat and a snapshot of the chosen slot
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         op_cmd_ff       <= command;
         op_expander_ff  <= expander;
         op_slot_ff      <= sel_slot;
         op_ok_ff        <= sel_ok;
         op_pin_ff       <= pin;
         op_level_ff     <= pin_value;
         op_read_word_ff <= read_word;
         op_count_ff     <= sel_count;
         op_head_ff      <= sel_head;
         op_last_sent_ff <= last_sent_ff[sel_slot];
         op_cache_ff     <= cache_ff[sel_slot];
      end
   end

   // Queue memory: registered read at capture, write at commit
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         mem_rd_ff <= fifo_mem[sel_slot][rd_ptr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit && push) begin
         fifo_mem[op_slot_ff][tail_ptr] <= new_word;
      end
   end

   // Build the new word for a pin write
   always_comb begin
      pin_ok    = (op_pin_ff != '0) && (int'(op_pin_ff) <= PIN_COUNT);
      pin_idx   = PIN_IDX_W'(op_pin_ff - PIN_W'(1));
      pin_mask  = WORD_W'(1) << pin_idx;
      base_word = (op_count_ff == '0) ? op_last_sent_ff : mem_rd_ff;
      new_word  = op_level_ff ? (base_word | pin_mask) : (base_word & ~pin_mask);
      tail_ptr  = wrap_ptr(QSUM_W'(op_head_ff) + QSUM_W'(op_count_ff));
      head_in   = wrap_ptr(QSUM_W'(op_head_ff) + QSUM_W'(1));
   end

   // Decide the result and the state updates
   always_comb begin
      action_in      = ACT_NONE;
      target_in      = '0;
      write_word_in  = '0;
      cached_word_in = '0;
      pin_state_in   = 1'b0;
      push           = 1'b0;
      pop            = 1'b0;
      cache_wr       = 1'b0;
      served_upd     = 1'b0;
      count_in       = op_count_ff;
      case (op_cmd_ff)
         CMD_POLL: begin
            if (op_ok_ff) begin
               served_upd = 1'b1;
               target_in  = EXP_W'(op_slot_ff);
               if (op_count_ff != '0) begin
                  pop           = 1'b1;
                  count_in      = op_count_ff - CNT_W'(1);
                  action_in     = ACT_WRITE;
                  write_word_in = mem_rd_ff;
               end else begin
                  action_in = ACT_READ;
               end
            end
         end
         CMD_QUEUE_PIN: begin
            // drop on a bad expander or pin, a full queue or a repeat of the newest entry
            if (op_ok_ff && pin_ok && (int'(op_count_ff) < QUEUE_DEPTH) &&
                (op_count_ff == '0 || new_word != mem_rd_ff)) begin
               push     = 1'b1;
               count_in = op_count_ff + CNT_W'(1);
            end
         end
         CMD_READ_DATA: begin
            cache_wr = op_ok_ff;
         end
         CMD_QUERY: begin
            action_in      = ACT_QUERY;
            target_in      = op_expander_ff;
            cached_word_in = op_ok_ff ? op_cache_ff : '0;
            pin_state_in   = pin_ok ? cached_word_in[pin_idx] : 1'b0;
         end
         default: ;
      endcase
   end

   // Per-expander state and last-served pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         last_served_ff <= '0;
         for (int s = 0; s < NUM_EXPANDERS; s++) begin
            count_ff[s]     <= '0;
            head_ff[s]      <= '0;
            last_sent_ff[s] <= '0;
            cache_ff[s]     <= '0;
         end
      end else if (ctrl_cmd.commit) begin
         if (served_upd) begin
            last_served_ff <= op_slot_ff;
         end
         if (push || pop) begin
            count_ff[op_slot_ff] <= count_in;
         end
         if (pop) begin
            head_ff[op_slot_ff]      <= head_in;
            last_sent_ff[op_slot_ff] <= mem_rd_ff;
         end
         if (cache_wr) begin
            cache_ff[op_slot_ff] <= op_read_word_ff;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         action_ff      <= action_in;
         target_ff      <= target_in;
         write_word_ff  <= write_word_in;
         cached_word_ff <= cached_word_in;
         pin_state_ff   <= pin_state_in;
      end
   end

   assign action      = action_ff;
   assign target      = target_ff;
   assign write_word  = write_word_ff;
   assign cached_word = cached_word_ff;
   assign pin_state   = pin_state_ff;

endmodule

>>> design/expander_write_queue_poller_core.sv
// ----------------------------------------------------------------------------
// expander_write_queue_poller_core: write-queue poller for GPIO expanders.
// Each beat is accepted in a cycle that picks the slot and reads the queue
// memory; its commit, once the response register is free or draining, updates
// state and loads that register. No new beat is taken until the last commits.
// Synchronous reset empties all queues and clears caches, sent words and enables.
// ----------------------------------------------------------------------------
module expander_write_queue_poller_core (
   input  logic        clock,
   input  logic        reset,
   ewqp_req_if.sink    req_bus,
   ewqp_rsp_if.source  rsp_bus,
   ewqp_csr_if.sink    csr_bus
);
   import ewqp_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   // Register port always takes writes
   assign csr_bus.ready = 1'b1;

   // Sequencer
   ewqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Queues, caches and response register
   ewqp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl_cmd    (ctrl_cmd),
      .csr_valid   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .command     (req_bus.command),
      .expander    (req_bus.expander),
      .pin         (req_bus.pin),
      .pin_value   (req_bus.pin_value),
      .read_word   (req_bus.read_word),
      .action      (rsp_bus.action),
      .target      (rsp_bus.target),
      .write_word  (rsp_bus.write_word),
      .cached_word (rsp_bus.cached_word),
      .pin_state   (rsp_bus.pin_state)
   );

endmodule

>>> design/ewqp_checker.sv
// ----------------------------------------------------------------------------
// ewqp_checker
// Port-level checks on the poller core, attached by bind.
// ----------------------------------------------------------------------------
module ewqp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input ewqp_pkg::action_type           rsp_action,
   input logic [ewqp_pkg::EXP_W-1:0]     rsp_target,
   input logic [ewqp_pkg::WORD_W-1:0]    rsp_write_word,
   input logic [ewqp_pkg::WORD_W-1:0]    rsp_cached_word,
   input logic                           rsp_pin_state
);
   import ewqp_pkg::*;

   // Reset leaves no response pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
         $stable(rsp_target) && $stable(rsp_write_word) &&
         $stable(rsp_cached_word) && $stable(rsp_pin_state))
      else $error("stalled response changed");

   // One beat in flight: an accepted request blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // An empty action carries an all-zero payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NONE |-> rsp_target == '0 &&
         rsp_write_word == '0 && rsp_cached_word == '0 && !rsp_pin_state)
      else $error("nonzero payload on empty action");

   // Only a write carries a write word, only a query carries cache data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_WRITE |-> rsp_write_word == '0 &&
         (rsp_action == ACT_QUERY || (rsp_cached_word == '0 && !rsp_pin_state)))
      else $error("payload field set for wrong action");

endmodule

bind expander_write_queue_poller_core ewqp_checker u_ewqp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_action      (rsp_bus.action),
   .rsp_target      (rsp_bus.target),
   .rsp_write_word  (rsp_bus.write_word),
   .rsp_cached_word (rsp_bus.cached_word),
   .rsp_pin_state   (rsp_bus.pin_state)
);
